FILE: sv/trp_pkg.sv
package trp_pkg;

  // Width of the zero-run and tail counters inside the block.
  localparam int COUNT_WIDTH = 16;

  localparam logic [7:0] SYNC_BYTE = 8'hE6;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    PH_FIRST    = 4'd0,
    PH_START_HI = 4'd1,
    PH_START_LO = 4'd2,
    PH_END_HI   = 4'd3,
    PH_END_LO   = 4'd4,
    PH_DATA     = 4'd5,
    PH_ZEROS    = 4'd6,
    PH_SUM_HI   = 4'd7,
    PH_SUM_LO   = 4'd8,
    PH_TAIL     = 4'd9,
    PH_ERROR    = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_END_BEFORE  = 2'd1,
    ST_TRUNCATED   = 2'd2,
    ST_NO_TRAILER  = 2'd3
  } status_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v != COUNT_MAX) ? v + COUNT_WIDTH'(1) : v;
  endfunction

  // Clamp a counter to the 16-bit report field.
  function automatic logic [15:0] report16(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+15:0] wide;
    wide = {16'd0, v};
    if (wide > (COUNT_WIDTH+16)'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return wide[15:0];
  endfunction

endpackage

FILE: sv/tape_record_parser_checker_core.sv
// Tape record parser / checker.
//
// Input channel (in_valid/in_ready): one record byte per word, byte_in plus
// last_byte, which flags the final byte of the record. Header (optional 0xE6
// sync, big-endian start and end address), data bytes, zero run, 0xE6
// trailer, big-endian stored checksum and tail bytes are walked by a phase
// register; all per-byte work is one short add/compare step.
//
// Output channel (out_valid/out_ready): one report word per record, built on
// the word flagged last. The report lands in the output register on the edge
// that accepts the last byte. Throughput is one byte per cycle when no report
// stalls, set by the single register stage around the parse step.
//
// The output register holds the report until it is taken. While it is full
// and out_ready is low, in_ready drops; otherwise a byte is taken every cycle,
// including the cycle the report is taken.
//
// Reset (rst, synchronous) returns the parser to awaiting the first byte and
// empties the output register. After each report the parser state is also
// cleared, ready for the next record. Errors stick until the last byte.
module tape_record_parser_checker_core
  import trp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        leading_sync,
  output logic [15:0] start_addr,
  output logic [15:0] end_addr,
  output logic [16:0] data_size,
  output logic [15:0] zero_count,
  output logic        trailer_sync,
  output logic [15:0] stored_sum,
  output logic [15:0] computed_sum,
  output logic        sum_match,
  output logic [15:0] tail_count,
  output logic [1:0]  status
);

  // parser state
  phase_t                 phase, phase_next;
  logic                   sync_seen, sync_seen_next;
  logic [15:0]            start_reg, start_reg_next;
  logic [15:0]            end_reg, end_reg_next;
  logic [16:0]            bytes_left, bytes_left_next;
  logic [16:0]            size_reg, size_reg_next;
  logic [15:0]            sum_acc, sum_acc_next;
  logic [COUNT_WIDTH-1:0] zeros_acc, zeros_acc_next;
  logic                   trailer_seen, trailer_seen_next;
  logic [15:0]            stored_acc, stored_acc_next;
  logic [COUNT_WIDTH-1:0] tail_acc, tail_acc_next;
  status_t                error_code, error_code_next;
  status_t                status_next;

  logic in_accept;
  logic out_accept;

  assign in_ready   = !out_valid || out_ready;
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  // one parse step
  always_comb begin
    phase_next        = phase;
    sync_seen_next    = sync_seen;
    start_reg_next    = start_reg;
    end_reg_next      = end_reg;
    bytes_left_next   = bytes_left;
    size_reg_next     = size_reg;
    sum_acc_next      = sum_acc;
    zeros_acc_next    = zeros_acc;
    trailer_seen_next = trailer_seen;
    stored_acc_next   = stored_acc;
    tail_acc_next     = tail_acc;
    error_code_next   = error_code;
    case (phase)
      PH_FIRST: begin
        if (byte_in == SYNC_BYTE) begin
          sync_seen_next = 1'b1;
          phase_next     = PH_START_HI;
        end else begin
          start_reg_next = {byte_in, 8'h00};
          phase_next     = PH_START_LO;
        end
      end
      PH_START_HI: begin
        start_reg_next = {byte_in, 8'h00};
        phase_next     = PH_START_LO;
      end
      PH_START_LO: begin
        start_reg_next = {start_reg[15:8], byte_in};
        phase_next     = PH_END_HI;
      end
      PH_END_HI: begin
        end_reg_next = {byte_in, 8'h00};
        phase_next   = PH_END_LO;
      end
      PH_END_LO: begin
        end_reg_next = {end_reg[15:8], byte_in};
        if (end_reg_next < start_reg) begin
          error_code_next = ST_END_BEFORE;
          size_reg_next   = 17'd0;
          phase_next      = PH_ERROR;
        end else begin
          size_reg_next   = {1'b0, end_reg_next} - {1'b0, start_reg} + 17'd1;
          bytes_left_next = size_reg_next;
          sum_acc_next    = 16'd0;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        // byte*257 mod 2^16 is the byte copied into both halves
        if (bytes_left > 17'd1) begin
          sum_acc_next = sum_acc + {byte_in, byte_in};
        end else begin
          sum_acc_next = sum_acc + {8'h00, byte_in};
        end
        if (bytes_left != 17'd0) begin
          bytes_left_next = bytes_left - 17'd1;
        end
        if (bytes_left_next == 17'd0) begin
          phase_next = PH_ZEROS;
        end
      end
      PH_ZEROS: begin
        if (byte_in == 8'h00) begin
          zeros_acc_next = sat_inc(zeros_acc);
        end else if (byte_in == SYNC_BYTE) begin
          trailer_seen_next = 1'b1;
          phase_next        = PH_SUM_HI;
        end else begin
          error_code_next = ST_NO_TRAILER;
          phase_next      = PH_ERROR;
        end
      end
      PH_SUM_HI: begin
        stored_acc_next = {byte_in, 8'h00};
        phase_next      = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        stored_acc_next = {stored_acc[15:8], byte_in};
        phase_next      = PH_TAIL;
      end
      PH_TAIL: begin
        tail_acc_next = sat_inc(tail_acc);
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // status as the report will carry it
  always_comb begin
    if (error_code_next != ST_OK) begin
      status_next = error_code_next;
    end else if (phase_next == PH_TAIL) begin
      status_next = ST_OK;
    end else begin
      status_next = ST_TRUNCATED;
    end
  end

  // parser registers: cleared by reset and after every report
  always_ff @(posedge clk) begin
    if (rst || (in_accept && last_byte)) begin
      phase        <= PH_FIRST;
      sync_seen    <= 1'b0;
      start_reg    <= 16'd0;
      end_reg      <= 16'd0;
      bytes_left   <= 17'd0;
      size_reg     <= 17'd0;
      sum_acc      <= 16'd0;
      zeros_acc    <= '0;
      trailer_seen <= 1'b0;
      stored_acc   <= 16'd0;
      tail_acc     <= '0;
      error_code   <= ST_OK;
    end else if (in_accept) begin
      phase        <= phase_next;
      sync_seen    <= sync_seen_next;
      start_reg    <= start_reg_next;
      end_reg      <= end_reg_next;
      bytes_left   <= bytes_left_next;
      size_reg     <= size_reg_next;
      sum_acc      <= sum_acc_next;
      zeros_acc    <= zeros_acc_next;
      trailer_seen <= trailer_seen_next;
      stored_acc   <= stored_acc_next;
      tail_acc     <= tail_acc_next;
      error_code   <= error_code_next;
    end
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  // output register: report payload
  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      leading_sync <= sync_seen_next;
      start_addr   <= start_reg_next;
      end_addr     <= end_reg_next;
      data_size    <= size_reg_next;
      zero_count   <= report16(zeros_acc_next);
      trailer_sync <= trailer_seen_next;
      stored_sum   <= stored_acc_next;
      computed_sum <= sum_acc_next;
      sum_match    <= (status_next == ST_OK) && (stored_acc_next == sum_acc_next);
      tail_count   <= report16(tail_acc_next);
      status       <= status_next;
    end
  end

  // checks
  a_no_take_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("byte taken while report stalled");

  a_report_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept && last_byte))
    else $error("report appeared without a last byte");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_byte) |=> (phase == PH_FIRST && error_code == ST_OK))
    else $error("parser not cleared after report");

  a_match_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sum_match) |-> (status == ST_OK))
    else $error("checksum match reported with bad status");

  a_bad_header_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_END_BEFORE) |-> (data_size == 17'd0))
    else $error("nonzero size on bad header");

endmodule

FILE: bench/tape_record_parser_checker_core_test.sv
`timescale 1ns / 100ps

module tape_record_parser_checker_core_test;
  import trp_pkg::*;

  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 1900;
  localparam int DIR_ROWS     = 26;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;   // expected report comes from the typed-in list
  } tape_word_t;

  typedef struct packed {
    logic        lead_sync;
    logic [15:0] start_a;
    logic [15:0] end_a;
    logic [16:0] size;
    logic [15:0] zeros;
    logic        trl_sync;
    logic [15:0] stored;
    logic [15:0] computed;
    logic        match;
    logic [15:0] tail;
    logic [1:0]  st;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        leading_sync;
  logic [15:0] start_addr;
  logic [15:0] end_addr;
  logic [16:0] data_size;
  logic [15:0] zero_count;
  logic        trailer_sync;
  logic [15:0] stored_sum;
  logic [15:0] computed_sum;
  logic        sum_match;
  logic [15:0] tail_count;
  logic [1:0]  status;

  tape_record_parser_checker_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .leading_sync (leading_sync),
    .start_addr   (start_addr),
    .end_addr     (end_addr),
    .data_size    (data_size),
    .zero_count   (zero_count),
    .trailer_sync (trailer_sync),
    .stored_sum   (stored_sum),
    .computed_sum (computed_sum),
    .sum_match    (sum_match),
    .tail_count   (tail_count),
    .status       (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stimulus words waiting to be sent; head is what the sender presents.
  tape_word_t  tape_q[$];
  // Reports the block owes us, oldest first.
  report_t     report_q[$];
  // Hand-written reports for the directed rows, in order.
  report_t     typed_q[$];
  // Scratch record under construction.
  logic [7:0]  rec[$];
  logic [8:0]  dir_tab [DIR_ROWS];

  int unsigned n_mismatch = 0;
  int unsigned idle_cycles = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int unsigned rx_cycle = 0;
  int          rx_mode = 0;

  // ---------------------------------------------------------------------------
  // Parser model: own copy of the record walk, advanced on every accepted word.
  // ---------------------------------------------------------------------------
  phase_t                 ph;
  logic                   p_sync;
  logic [15:0]            p_start;
  logic [15:0]            p_end;
  logic [16:0]            p_left;
  logic [16:0]            p_size;
  logic [15:0]            p_sum;
  logic [COUNT_WIDTH-1:0] p_zeros;
  logic                   p_trl;
  logic [15:0]            p_stored;
  logic [COUNT_WIDTH-1:0] p_tail;
  logic [1:0]             p_err;

  task automatic clear_parser();
    ph       = PH_FIRST;
    p_sync   = 1'b0;
    p_start  = '0;
    p_end    = '0;
    p_left   = '0;
    p_size   = '0;
    p_sum    = '0;
    p_zeros  = '0;
    p_trl    = 1'b0;
    p_stored = '0;
    p_tail   = '0;
    p_err    = ST_OK;
  endtask

  // Counters are reported through a 16-bit field; clamp anything wider.
  function automatic logic [15:0] clamp16(input logic [COUNT_WIDTH-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return (w > 48'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic lst,
                            output bit has_rep, output report_t r);
    logic [1:0] st;
    case (ph)
      PH_FIRST: begin
        if (b == SYNC_BYTE) begin
          p_sync = 1'b1;
          ph = PH_START_HI;
        end else begin
          p_start = {b, 8'h00};
          ph = PH_START_LO;
        end
      end
      PH_START_HI: begin
        p_start = {b, 8'h00};
        ph = PH_START_LO;
      end
      PH_START_LO: begin
        p_start[7:0] = b;
        ph = PH_END_HI;
      end
      PH_END_HI: begin
        p_end = {b, 8'h00};
        ph = PH_END_LO;
      end
      PH_END_LO: begin
        p_end[7:0] = b;
        if (p_end < p_start) begin
          p_err = ST_END_BEFORE;
          p_size = '0;
          ph = PH_ERROR;
        end else begin
          p_size = {1'b0, p_end} - {1'b0, p_start} + 17'd1;
          p_left = p_size;
          p_sum = '0;
          ph = PH_DATA;
        end
      end
      PH_DATA: begin
        // every data byte weighs 257 except the final one
        if (p_left > 17'd1) p_sum = p_sum + {b, b};
        else p_sum = p_sum + {8'h00, b};
        if (p_left != '0) p_left = p_left - 17'd1;
        if (p_left == '0) ph = PH_ZEROS;
      end
      PH_ZEROS: begin
        if (b == 8'h00) begin
          if (p_zeros != {COUNT_WIDTH{1'b1}}) p_zeros = p_zeros + COUNT_WIDTH'(1);
        end else if (b == SYNC_BYTE) begin
          p_trl = 1'b1;
          ph = PH_SUM_HI;
        end else begin
          p_err = ST_NO_TRAILER;
          ph = PH_ERROR;
        end
      end
      PH_SUM_HI: begin
        p_stored = {b, 8'h00};
        ph = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        p_stored[7:0] = b;
        ph = PH_TAIL;
      end
      PH_TAIL: begin
        if (p_tail != {COUNT_WIDTH{1'b1}}) p_tail = p_tail + COUNT_WIDTH'(1);
      end
      default: ph = PH_ERROR;   // error: soak up bytes until last
    endcase

    has_rep = lst;
    r = '0;
    if (lst) begin
      if (p_err != ST_OK) st = p_err;
      else if (ph == PH_TAIL) st = ST_OK;
      else st = ST_TRUNCATED;
      r = '{p_sync, p_start, p_end, p_size, clamp16(p_zeros), p_trl, p_stored,
            p_sum, (st == ST_OK) && (p_stored == p_sum), clamp16(p_tail), st};
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Record generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return SYNC_BYTE;
      2: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Append n data bytes and return the checksum they should carry.
  task automatic push_data(input int n, output logic [15:0] sum);
    logic [7:0] d;
    sum = 16'h0000;
    for (int i = 0; i < n; i++) begin
      d = pick_byte();
      rec.push_back(d);
      sum = sum + ((i < n - 1) ? {d, d} : {8'h00, d});
    end
  endtask

  // Move the first cut bytes of the record into the send queue; last on the final one.
  task automatic emit_record(input int cut);
    for (int i = 0; i < cut; i++) begin
      tape_q.push_back('{b: rec[i], last: (i == cut - 1), typed: 1'b0});
    end
  endtask

  task automatic build_record();
    int          kind;
    int          n;
    int          cut;
    logic [15:0] s_addr;
    logic [15:0] e_addr;
    logic [15:0] sum;
    logic [7:0]  bad;
    rec = {};
    kind = $urandom_range(0, 99);
    // 0..69 well formed (some cut short), 70..79 bad header,
    // 80..89 junk where the trailer belongs, 90..99 plain noise
    if (kind >= 90) begin
      repeat ($urandom_range(1, 20)) rec.push_back(pick_byte());
      emit_record(rec.size());
      return;
    end
    if ($urandom_range(0, 1) != 0) rec.push_back(SYNC_BYTE);
    n = 1;
    if (kind >= 70 && kind < 80) begin
      s_addr = 16'($urandom_range(1, 65535));
      e_addr = 16'($urandom_range(0, s_addr - 1));
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
      case ($urandom_range(0, 7))
        0: s_addr = 16'h0000;
        1: s_addr = 16'(65536 - n);
        default: s_addr = 16'($urandom_range(0, 65536 - n));
      endcase
      e_addr = s_addr + 16'(n - 1);
    end
    rec.push_back(s_addr[15:8]);
    rec.push_back(s_addr[7:0]);
    rec.push_back(e_addr[15:8]);
    rec.push_back(e_addr[7:0]);
    if (kind >= 70 && kind < 80) begin
      repeat ($urandom_range(0, 3)) rec.push_back(pick_byte());
      emit_record(rec.size());
      return;
    end
    push_data(n, sum);
    repeat ($urandom_range(0, 5)) rec.push_back(8'h00);
    if (kind >= 80) begin
      do bad = 8'($urandom_range(1, 255)); while (bad == SYNC_BYTE);
      rec.push_back(bad);
      repeat ($urandom_range(0, 3)) rec.push_back(pick_byte());
    end else begin
      rec.push_back(SYNC_BYTE);
      if ($urandom_range(0, 4) == 0) sum = 16'($urandom);
      rec.push_back(sum[15:8]);
      rec.push_back(sum[7:0]);
      repeat ($urandom_range(0, 4)) rec.push_back(pick_byte());
    end
    cut = rec.size();
    if (kind < 70 && $urandom_range(0, 6) == 0) cut = $urandom_range(1, rec.size());
    emit_record(cut);
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch logging: first ten in full, the rest only counted.
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input bit unexpected, input report_t want, input report_t got);
    if (n_mismatch < 10) begin
      if (unexpected) begin
        $display("mismatch @%0t: report with none expected", $realtime);
      end else begin
        $display("mismatch @%0t: exp sync=%0d start=%h end=%h size=%h zeros=%h trl=%0d",
                 $realtime, want.lead_sync, want.start_a, want.end_a, want.size,
                 want.zeros, want.trl_sync);
        $display("  exp stored=%h computed=%h match=%0d tail=%h status=%0d",
                 want.stored, want.computed, want.match, want.tail, want.st);
      end
      $display("  got sync=%0d start=%h end=%h size=%h zeros=%h trl=%0d",
               got.lead_sync, got.start_a, got.end_a, got.size, got.zeros, got.trl_sync);
      $display("  got stored=%h computed=%h match=%0d tail=%h status=%0d",
               got.stored, got.computed, got.match, got.tail, got.st);
    end
    n_mismatch++;
  endtask

  // ---------------------------------------------------------------------------
  // Both channels: predict on every accepted byte word, check every report
  // word, then drive next cycle's inputs.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t got;
    report_t want;
    bit      has_rep;
    if (rst) begin
      clear_parser();
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(byte_in, last_byte, has_rep, want);
        if (has_rep) begin
          if (tape_q[0].typed) report_q.push_back(typed_q.pop_front());
          else report_q.push_back(want);
        end
        void'(tape_q.pop_front());
      end

      if (out_valid && out_ready) begin
        got = '{leading_sync, start_addr, end_addr, data_size, zero_count, trailer_sync,
                stored_sum, computed_sum, sum_match, tail_count, status};
        if (report_q.size() == 0) begin
          log_mismatch(1'b1, '0, got);
        end else begin
          want = report_q.pop_front();
          if (got !== want) log_mismatch(1'b0, want, got);
        end
      end

      // sender: bursts of words with idle gaps between; hold while stalled
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tape_q.size() != 0) begin
          in_valid  <= 1'b1;
          byte_in   <= tape_q[0].b;
          last_byte <= tape_q[0].last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end

      // receiver: switches between always-ready, coin flip and a fixed pattern
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_cycle % 5) >= 2;
      endcase
    end
  end

  // Hang detector: nothing moving on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and run control
  // ---------------------------------------------------------------------------
  initial begin
    int base;

    // Directed rows {last, byte}: short records hitting each special case.
    dir_tab = '{
      // last on the very first byte: truncated, start high byte only
      {1'b1, 8'hFF},
      // lone sync byte then last: truncated, sync flagged
      {1'b1, 8'hE6},
      // start FFFF, end 0000: end before start
      {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b1, 8'h00},
      // one data byte, one zero, trailer, matching sum: clean record
      {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00},
      {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hE6}, {1'b0, 8'h00}, {1'b1, 8'hFF},
      // junk where the trailer belongs
      {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00},
      {1'b0, 8'h12}, {1'b1, 8'h34},
      // sync, header FFFF..FFFF, last before any data
      {1'b0, 8'hE6}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF}
    };
    // sync start end size zeros trl stored computed match tail status
    typed_q.push_back('{1'b0, 16'hFF00, 16'h0000, 17'h0, 16'h0, 1'b0, 16'h0, 16'h0,
                        1'b0, 16'h0, ST_TRUNCATED});
    typed_q.push_back('{1'b1, 16'h0000, 16'h0000, 17'h0, 16'h0, 1'b0, 16'h0, 16'h0,
                        1'b0, 16'h0, ST_TRUNCATED});
    typed_q.push_back('{1'b0, 16'hFFFF, 16'h0000, 17'h0, 16'h0, 1'b0, 16'h0, 16'h0,
                        1'b0, 16'h0, ST_END_BEFORE});
    typed_q.push_back('{1'b0, 16'h0000, 16'h0000, 17'h1, 16'h1, 1'b1, 16'h00FF, 16'h00FF,
                        1'b1, 16'h0, ST_OK});
    typed_q.push_back('{1'b0, 16'h0000, 16'h0000, 17'h1, 16'h0, 1'b0, 16'h0, 16'h0012,
                        1'b0, 16'h0, ST_NO_TRAILER});
    typed_q.push_back('{1'b1, 16'hFFFF, 16'hFFFF, 17'h1, 16'h0, 1'b0, 16'h0, 16'h0,
                        1'b0, 16'h0, ST_TRUNCATED});
    foreach (dir_tab[i]) begin
      tape_q.push_back('{b: dir_tab[i][7:0], last: dir_tab[i][8], typed: dir_tab[i][8]});
    end

    // Random records after the directed rows.
    base = tape_q.size();
    while (tape_q.size() < base + RANDOM_WORDS) build_record();
    rec = {};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // drain: every word sent and every report back
    do @(posedge clk); while (tape_q.size() != 0 || report_q.size() != 0);
    repeat (16) @(posedge clk);

    if (n_mismatch == 0 && report_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
